FILE: hdl/hsl2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared widths, hue constants and segment codes of the HSL to RGB converter.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

  localparam int unsigned HueW   = 16;
  localparam int unsigned FracW  = 17;   // Q0.16 with room for 1.0
  localparam int unsigned ChanW  = 8;
  localparam int unsigned TurnW  = 18;   // hue in 1/196608 turn units
  localparam int unsigned DiffW  = 32;   // v2 - l, or l - v1
  localparam int unsigned LevW   = 33;   // v1, v2 and span, Q0.32 up to 1.0
  localparam int unsigned DistW  = 16;   // distance into a ramp, up to 1/6 turn
  localparam int unsigned NumW   = 48;   // hue function times 2^47
  localparam int unsigned ScaleW = 56;   // 255 * num plus rounding

  localparam logic [FracW-1:0] OneQ16  = FracW'(65536);
  localparam logic [FracW-1:0] HalfQ16 = FracW'(32768);

  localparam logic [TurnW-1:0] HueTurn  = TurnW'(196608);
  localparam logic [TurnW-1:0] HueThird = TurnW'(65536);
  localparam logic [TurnW-1:0] SixthT   = TurnW'(32768);
  localparam logic [TurnW-1:0] HalfT    = TurnW'(98304);
  localparam logic [TurnW-1:0] TwoThirdT = TurnW'(131072);

  localparam logic [ScaleW-1:0] RoundHalf = ScaleW'(64'h4000_0000_0000);  // 2^46
  localparam logic [ChanW-1:0]  ChanMax   = ChanW'(255);

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_e;

endpackage

FILE: hdl/hsl2rgb_chan.sv
// ----------------------------------------------------------------------------
// hsl2rgb_chan
// One color channel: hue segment select, ramp multiply, sum, and scaling
// to 8 bits with rounding and saturation, over four register stages.
// ----------------------------------------------------------------------------
module hsl2rgb_chan
  import hsl2rgb_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [TurnW-1:0] hue_i,    // shifted hue, stage 1 register
  input  logic [LevW-1:0]  v1_i,     // stage 2 register
  input  logic [LevW-1:0]  v2_i,     // stage 2 register
  input  logic [LevW-1:0]  span_i,   // stage 2 register
  output logic [ChanW-1:0] chan_o
);

  seg_e             seg_d, seg_q;
  logic [DistW-1:0] dist_d, dist_q;

  logic [LevW+DistW-1:0] prod_d, prod_q;
  logic [NumW-1:0]       base_d, base_q;
  logic                  ramp_d, ramp_q;

  logic [NumW-1:0]   num_d, num_q;
  logic [ScaleW-1:0] scaled;
  logic [ChanW:0]    chan_wide;
  logic [ChanW-1:0]  chan_d, chan_q;

  // stage 2: which piece of the hue function
  always_comb begin
    dist_d = '0;
    if (hue_i < SixthT) begin
      seg_d  = SEG_RISE;
      dist_d = hue_i[DistW-1:0];
    end else if (hue_i < HalfT) begin
      seg_d = SEG_HIGH;
    end else if (hue_i < TwoThirdT) begin
      seg_d  = SEG_FALL;
      dist_d = DistW'(TwoThirdT - hue_i);
    end else begin
      seg_d = SEG_LOW;
    end
  end

  // stage 3: ramp product and the flat part
  always_comb begin
    prod_d = (LevW+DistW)'(span_i) * (LevW+DistW)'(dist_q);
    ramp_d = (seg_q == SEG_RISE) || (seg_q == SEG_FALL);
    base_d = (seg_q == SEG_HIGH) ? {v2_i, 15'd0} : {v1_i, 15'd0};
  end

  // stage 4
  assign num_d = base_q + (ramp_q ? prod_q[NumW-1:0] : '0);

  // stage 5: 255 * num / 2^47, rounded half up
  always_comb begin
    scaled    = ({num_q, 8'd0} - ScaleW'(num_q)) + RoundHalf;
    chan_wide = scaled[ScaleW-1 -: ChanW+1];
    chan_d    = chan_wide[ChanW] ? ChanMax : chan_wide[ChanW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg_q  <= seg_d;
      dist_q <= dist_d;
      prod_q <= prod_d;
      base_q <= base_d;
      ramp_q <= ramp_d;
      num_q  <= num_d;
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

FILE: hdl/hsl_to_rgb_pixel.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_pixel
// Converts a stream of pixels from hue, saturation and lightness to 8-bit RGB.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis: hue (16 bits, fraction of a turn), saturation
// and lightness (17 bits each, Q0.16, values above 1.0 are taken as 1.0).
// Result words leave on m_axis as red, green and blue, 8 bits each.
// The datapath is a five stage pipeline: clamp and l*s multiply, v1/v2 and
// span, one ramp multiply per channel, the sum, then scaling by 255 with
// rounding into the output register.
// One word is accepted every cycle while the output side takes words; the
// ramp multiplier of each channel sets the stage depth.
// When the receiver stalls with a word in the output register the whole
// pipeline holds; s_axis_tready_o falls and nothing is lost or repeated.
// Bubbles in the pipeline keep moving while the output register is empty.
// Reset clears all valid bits; the block then accepts words at once.
// ----------------------------------------------------------------------------
module hsl_to_rgb_pixel
  import hsl2rgb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,   // hue [15:0], saturation [32:16], lightness [49:33]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // red [7:0], green [15:8], blue [23:16]
);

  localparam int unsigned Stages = 5;

  logic              en;
  logic [Stages-1:0] vld_d, vld_q;

  logic [HueW-1:0]  hue_in;
  logic [FracW-1:0] sat_in, lit_in, sat_c, lit_c;

  logic [TurnW-1:0]   hue3, hue_r_d, hue_b_d;
  logic [TurnW-1:0]   hue_r_q, hue_g_q, hue_b_q;
  logic [FracW-1:0]   sat_q, lit_q;
  logic [2*FracW-1:0] ls_d, ls_q;
  logic               low_q;

  logic [DiffW-1:0] diff;
  logic [LevW-1:0]  lit_sh;
  logic [LevW-1:0]  v1_d, v2_d, span_d, v1_q, v2_q, span_q;

  logic [ChanW-1:0] red, green, blue;

  // the pipeline moves whenever the output register can take a word
  assign en              = !vld_q[Stages-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign vld_d           = {vld_q[Stages-2:0], s_axis_tvalid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // stage 1: clamp, l*s, hue shifted by a third of a turn each way
  always_comb begin
    hue_in = s_axis_tdata_i[15:0];
    sat_in = s_axis_tdata_i[32:16];
    lit_in = s_axis_tdata_i[49:33];
    sat_c  = (sat_in > OneQ16) ? OneQ16 : sat_in;
    lit_c  = (lit_in > OneQ16) ? OneQ16 : lit_in;
    ls_d   = (2*FracW)'(sat_c) * (2*FracW)'(lit_c);
    hue3   = TurnW'(hue_in) + {hue_in, 1'b0};
    hue_r_d = (hue3 >= (HueTurn - HueThird)) ? hue3 - (HueTurn - HueThird)
                                             : hue3 + HueThird;
    hue_b_d = (hue3 >= HueThird) ? hue3 - HueThird : hue3 + (HueTurn - HueThird);
  end

  // stage 2: v2 = l + diff, v1 = l - diff, span = 2 * diff
  always_comb begin
    lit_sh = {lit_q[15:0], 16'd0} | (LevW'(lit_q[16]) << 32);
    diff   = low_q ? ls_q[DiffW-1:0]
                   : DiffW'({sat_q, 16'd0} - ls_q);
    v2_d   = lit_sh + LevW'(diff);
    v1_d   = lit_sh - LevW'(diff);
    span_d = {diff, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_r_q <= hue_r_d;
      hue_g_q <= hue3;
      hue_b_q <= hue_b_d;
      sat_q   <= sat_c;
      lit_q   <= lit_c;
      ls_q    <= ls_d;
      low_q   <= (lit_c < HalfQ16);
      v1_q    <= v1_d;
      v2_q    <= v2_d;
      span_q  <= span_d;
    end
  end

  hsl2rgb_chan u_chan_r (
    .clk_i  (clk_i),
    .en_i   (en),
    .hue_i  (hue_r_q),
    .v1_i   (v1_q),
    .v2_i   (v2_q),
    .span_i (span_q),
    .chan_o (red)
  );

  hsl2rgb_chan u_chan_g (
    .clk_i  (clk_i),
    .en_i   (en),
    .hue_i  (hue_g_q),
    .v1_i   (v1_q),
    .v2_i   (v2_q),
    .span_i (span_q),
    .chan_o (green)
  );

  hsl2rgb_chan u_chan_b (
    .clk_i  (clk_i),
    .en_i   (en),
    .hue_i  (hue_b_q),
    .v1_i   (v1_q),
    .v2_i   (v2_q),
    .span_i (span_q),
    .chan_o (blue)
  );

  assign m_axis_tvalid_o = vld_q[Stages-1];
  assign m_axis_tdata_o  = {blue, green, red};

endmodule
